// ===== rtl/core/fpa_pkg.sv =====
`timescale 1ns / 1ps
package fpa_pkg;

  // Default sizing
  localparam int MAX_BLOCKS_DEF  = 64;
  localparam int RUN_BYTES_DEF   = 1048576;
  localparam int PAGE_BYTES_DEF  = 4096;
  localparam int SMALL_ALIGN_DEF = 16;

  // Result status codes
  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
  localparam logic [2:0] ST_FREED     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;
  localparam logic [2:0] ST_TABLE_FULL = 3'd5;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ARENA_BASE  = 1'b0;
  localparam logic CFG_ARENA_LIMIT = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] request_size;
    logic [31:0] owner_tag;
    logic        zero_wanted;
    logic [47:0] free_address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] block_address;
    logic [31:0] freed_size;
    logic [31:0] freed_tag;
    logic        zero_fill;
  } res_t;

  // One block table row
  typedef struct packed {
    logic [47:0] base;
    logic [32:0] size;
    logic        free;
    logic [31:0] requested;
    logic [31:0] tag;
  } entry_t;

endpackage

// ===== rtl/core/fpa_table.sv =====
`timescale 1ns / 1ps
module fpa_table
  import fpa_pkg::*;
#(
  parameter int DEPTH = MAX_BLOCKS_DEF,
  parameter int IW    = $clog2(MAX_BLOCKS_DEF)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [IW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/first_fit_pool_allocator_top.sv =====
`timescale 1ns / 1ps
// Channel   Ports                               Handshake
// input     start, busy, in_data (req_t)        taken when start & !busy
// result    out_valid, out_data (res_t)         one-cycle strobe, no back-pressure
// config    cfg_we, cfg_index, cfg_wdata        written when cfg_we is high
//
// One word at a time. A free-table walk reads each row in S_SCAN_RD and checks it in
// S_SCAN_CHK (table read port is registered); moving rows for a split or merge reads
// each moved row in S_SH_RD and writes it in S_SH_WR, plus setup and bookkeeping states.
// Reset (rst_n low, synchronous) empties the table and rewinds the arena;
// no clearing pass. Results cannot be stalled by the receiver.
module first_fit_pool_allocator_top
  import fpa_pkg::*;
#(
  parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
  parameter int RUN_BYTES   = RUN_BYTES_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int SMALL_ALIGN = SMALL_ALIGN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  req_t        in_data,
  output logic        out_valid,
  output res_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_wdata
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int MW = $clog2(PAGE_BYTES);
  localparam logic [32:0] SA_M33   = 33'(SMALL_ALIGN - 1);
  localparam logic [MW-1:0] SA_M   = MW'(SMALL_ALIGN - 1);
  localparam logic [MW-1:0] PG_M   = MW'(PAGE_BYTES - 1);
  localparam logic [33:0] PG_M34   = 34'(PAGE_BYTES - 1);
  localparam logic [33:0] RUN_34   = 34'(RUN_BYTES);
  localparam logic [49:0] TOP_50   = 50'h1_0000_0000_0000;
  localparam logic [CW:0] MAX_CNT  = (CW+1)'(MAX_BLOCKS);

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_RUN, S_RES, S_CHECK, S_PLAN,
    S_SH_RD, S_SH_WR, S_WR_LEAD, S_WR_ALLOC, S_WR_TAIL,
    S_FN_RD, S_FN_CHK, S_FP, S_FWR, S_DONE
  } state_t;

  state_t        state_r;
  logic [47:0]   arena_base_r, arena_limit_r, next_off_r;
  logic [CW-1:0] count_r, j_r, idx_r, ins_idx_r, i_r;
  logic          ins_set_r, found_r, cmd_r, zero_r;
  logic [31:0]   size_r, tag_r;
  logic [47:0]   faddr_r;
  logic [32:0]   needed_r;
  logic [MW-1:0] lmask_r, lead_r;
  logic [48:0]   newbase_r, bbase_r;
  logic [33:0]   bsize_r, want_r, reserved_r, tail_r;
  entry_t        prev_r, cur_r;
  logic          nmerge_r, pmerge_r;
  logic [32:0]   cursize_r;
  logic [CW-1:0] sh_src_r, sh_rem_r;
  logic [1:0]    sh_dist_r;
  logic          sh_up_r;
  res_t          out_r;

  // table port
  logic          t_we;
  logic [IW-1:0] t_wa, t_ra;
  entry_t        t_wd, t_rd;

  fpa_table #(.DEPTH(MAX_BLOCKS), .IW(IW)) u_table (
    .clk(clk), .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
    .rd_addr(t_ra), .rd_data(t_rd)
  );

  // shared datapath terms
  logic [MW-1:0] scan_lead;
  logic [33:0]   scan_need;
  logic          scan_fit;
  logic [48:0]   alloc_addr;
  logic [CW-1:0] alloc_pos;
  logic [33:0]   plan_tail;
  logic [1:0]    plan_extra;
  logic [CW-1:0] sh_start;
  logic [48:0]   cur_end, prev_end;
  logic [33:0]   nsum, psum;
  logic          nmerge, pmerge;
  logic [1:0]    merges;
  logic [CW-1:0] fr_src;
  logic [49:0]   run_end;
  logic [48:0]   off_end;

  always_comb begin
    scan_lead  = (~t_rd.base[MW-1:0] + MW'(1)) & lmask_r;
    scan_need  = 34'(scan_lead) + 34'(needed_r);
    scan_fit   = t_rd.free && ({1'b0, t_rd.size} >= scan_need);
    alloc_addr = bbase_r + 49'(lead_r);
    alloc_pos  = idx_r + CW'(lead_r != '0);
    plan_tail  = bsize_r - 34'(lead_r) - 34'(needed_r);
    plan_extra = 2'(!found_r) + 2'(lead_r != '0) + 2'(plan_tail != '0);
    sh_start   = idx_r + CW'(found_r);
    run_end    = 50'(newbase_r) + 50'(reserved_r);
    off_end    = 49'(next_off_r) + 49'(reserved_r);
    cur_end    = 49'(faddr_r) + 49'(cur_r.size);
    nsum       = {1'b0, cur_r.size} + {1'b0, t_rd.size};
    nmerge     = t_rd.free && (cur_end == {1'b0, t_rd.base}) && !nsum[33];
    prev_end   = 49'(prev_r.base) + 49'(prev_r.size);
    psum       = {1'b0, prev_r.size} + {1'b0, cursize_r};
    pmerge     = (i_r != '0) && prev_r.free && (prev_end == {1'b0, faddr_r}) && !psum[33];
    merges     = 2'(nmerge_r) + 2'(pmerge_r);
    fr_src     = i_r + CW'(1) + CW'(nmerge_r);
  end

  // table port control
  always_comb begin
    t_we = 1'b0;
    t_wa = '0;
    t_ra = '0;
    t_wd = t_rd;
    case (state_r)
      S_SCAN_RD: t_ra = j_r[IW-1:0];
      S_FN_RD:   t_ra = IW'(i_r + CW'(1));
      S_SH_RD:   t_ra = sh_src_r[IW-1:0];
      S_SH_WR: begin
        t_we = 1'b1;
        t_wa = sh_up_r ? IW'(sh_src_r + CW'(sh_dist_r)) : IW'(sh_src_r - CW'(sh_dist_r));
      end
      S_WR_LEAD: begin
        t_we = 1'b1;
        t_wa = idx_r[IW-1:0];
        t_wd = '{base: bbase_r[47:0], size: 33'(lead_r), free: 1'b1,
                 requested: '0, tag: '0};
      end
      S_WR_ALLOC: begin
        t_we = 1'b1;
        t_wa = alloc_pos[IW-1:0];
        t_wd = '{base: alloc_addr[47:0], size: needed_r, free: 1'b0,
                 requested: size_r, tag: tag_r};
      end
      S_WR_TAIL: begin
        t_we = 1'b1;
        t_wa = IW'(alloc_pos + CW'(1));
        t_wd = '{base: 48'(alloc_addr + 49'(needed_r)), size: tail_r[32:0], free: 1'b1,
                 requested: '0, tag: '0};
      end
      S_FWR: begin
        t_we = 1'b1;
        if (pmerge_r) begin
          t_wa = IW'(i_r - CW'(1));
          t_wd = '{base: prev_r.base, size: psum[32:0], free: 1'b1,
                   requested: prev_r.requested, tag: prev_r.tag};
        end else begin
          t_wa = i_r[IW-1:0];
          t_wd = '{base: cur_r.base, size: cursize_r, free: 1'b1,
                   requested: cur_r.requested, tag: cur_r.tag};
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      arena_base_r  <= '0;
      arena_limit_r <= '0;
      next_off_r    <= '0;
      count_r       <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ARENA_BASE) arena_base_r <= cfg_wdata;
        else                             arena_limit_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r     <= in_data.command;
            size_r    <= in_data.request_size;
            tag_r     <= in_data.owner_tag;
            zero_r    <= in_data.zero_wanted;
            faddr_r   <= in_data.free_address;
            needed_r  <= ({1'b0, in_data.request_size} + SA_M33) & ~SA_M33;
            lmask_r   <= (in_data.request_size >= 32'(PAGE_BYTES)) ? PG_M : SA_M;
            newbase_r <= 49'(arena_base_r) + 49'(next_off_r);
            j_r       <= '0;
            ins_idx_r <= count_r;
            ins_set_r <= 1'b0;
            found_r   <= 1'b0;
            if (in_data.command == CMD_ALLOC && in_data.request_size == '0) begin
              out_r   <= '{status: ST_ZERO_SIZE, block_address: '0, freed_size: '0,
                           freed_tag: '0, zero_fill: 1'b0};
              state_r <= S_DONE;
            end else begin
              out_r   <= '0;
              state_r <= S_SCAN_RD;
            end
          end
        end
        // walk the table, reading each row and then checking it
        S_SCAN_RD: begin
          if (j_r == count_r) begin
            if (cmd_r == CMD_ALLOC) begin
              state_r <= S_RUN;
            end else begin
              out_r.status <= ST_NOT_FOUND;
              state_r      <= S_DONE;
            end
          end else begin
            state_r <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (cmd_r == CMD_ALLOC) begin
            if (!ins_set_r && ({1'b0, t_rd.base} > newbase_r)) begin
              ins_idx_r <= j_r;
              ins_set_r <= 1'b1;
            end
            if (scan_fit) begin
              found_r <= 1'b1;
              idx_r   <= j_r;
              bbase_r <= {1'b0, t_rd.base};
              bsize_r <= {1'b0, t_rd.size};
              lead_r  <= scan_lead;
              state_r <= S_PLAN;
            end else begin
              j_r     <= j_r + CW'(1);
              state_r <= S_SCAN_RD;
            end
          end else if (t_rd.base == faddr_r) begin
            if (t_rd.free) begin
              out_r.status <= ST_NOT_FOUND;
              state_r      <= S_DONE;
            end else begin
              cur_r   <= t_rd;
              i_r     <= j_r;
              state_r <= S_FN_RD;
            end
          end else begin
            prev_r  <= t_rd;
            j_r     <= j_r + CW'(1);
            state_r <= S_SCAN_RD;
          end
        end
        // new run sizing
        S_RUN: begin
          want_r  <= ((34'(needed_r) + 34'(lmask_r) + 34'd1) < RUN_34) ? RUN_34
                     : (34'(needed_r) + 34'(lmask_r) + 34'd1);
          state_r <= S_RES;
        end
        S_RES: begin
          reserved_r <= (want_r + PG_M34) & ~PG_M34;
          state_r    <= S_CHECK;
        end
        S_CHECK: begin
          if (off_end > {1'b0, arena_limit_r} || run_end > TOP_50) begin
            out_r.status <= ST_EXHAUSTED;
            state_r      <= S_DONE;
          end else begin
            bbase_r <= newbase_r;
            bsize_r <= reserved_r;
            lead_r  <= (~newbase_r[MW-1:0] + MW'(1)) & lmask_r;
            idx_r   <= ins_idx_r;
            state_r <= S_PLAN;
          end
        end
        S_PLAN: begin
          if ((CW+1)'(count_r) + (CW+1)'(plan_extra) > MAX_CNT) begin
            out_r.status <= ST_TABLE_FULL;
            state_r      <= S_DONE;
          end else begin
            if (!found_r) next_off_r <= off_end[47:0];
            count_r   <= count_r + CW'(plan_extra);
            tail_r    <= plan_tail;
            sh_up_r   <= 1'b1;
            sh_dist_r <= plan_extra;
            sh_src_r  <= count_r - CW'(1);
            sh_rem_r  <= (plan_extra == '0) ? '0 : count_r - sh_start;
            out_r.status        <= ST_ALLOCATED;
            out_r.block_address <= alloc_addr[47:0];
            out_r.zero_fill     <= zero_r;
            state_r   <= S_SH_RD;
          end
        end
        // move rows up or down by sh_dist
        S_SH_RD: begin
          if (sh_rem_r == '0) begin
            if (cmd_r == CMD_FREE)  state_r <= S_DONE;
            else if (lead_r != '0)  state_r <= S_WR_LEAD;
            else                    state_r <= S_WR_ALLOC;
          end else begin
            state_r <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          sh_src_r <= sh_up_r ? sh_src_r - CW'(1) : sh_src_r + CW'(1);
          sh_rem_r <= sh_rem_r - CW'(1);
          state_r  <= S_SH_RD;
        end
        S_WR_LEAD:  state_r <= S_WR_ALLOC;
        S_WR_ALLOC: state_r <= (tail_r != '0) ? S_WR_TAIL : S_DONE;
        S_WR_TAIL:  state_r <= S_DONE;
        // free: look at the following row
        S_FN_RD: begin
          out_r.status     <= ST_FREED;
          out_r.freed_size <= cur_r.requested;
          out_r.freed_tag  <= cur_r.tag;
          if (i_r + CW'(1) < count_r) begin
            state_r <= S_FN_CHK;
          end else begin
            nmerge_r  <= 1'b0;
            cursize_r <= cur_r.size;
            state_r   <= S_FP;
          end
        end
        S_FN_CHK: begin
          nmerge_r  <= nmerge;
          cursize_r <= nmerge ? nsum[32:0] : cur_r.size;
          state_r   <= S_FP;
        end
        S_FP: begin
          pmerge_r <= pmerge;
          state_r  <= S_FWR;
        end
        S_FWR: begin
          count_r   <= count_r - CW'(merges);
          sh_up_r   <= 1'b0;
          sh_dist_r <= merges;
          sh_src_r  <= fr_src;
          sh_rem_r  <= (merges == '0) ? '0 : count_r - fr_src;
          state_r   <= S_SH_RD;
        end
        S_DONE:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data  = out_r;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import fpa_pkg::*;

  localparam int NBLK  = MAX_BLOCKS_DEF;
  localparam longint RUNB = RUN_BYTES_DEF;
  localparam longint PAGE = PAGE_BYTES_DEF;
  localparam longint SAL  = SMALL_ALIGN_DEF;
  localparam longint LIM48 = 64'h1_0000_0000_0000;
  localparam longint MAX33 = 64'h1_FFFF_FFFF;
  localparam int WATCHDOG = 20000;

  // Scoreboard: mirror of the block table and queue of expected words
  class pool_scoreboard;
    longint unsigned base_q[$];
    longint unsigned size_q[$];
    bit free_q[$];
    bit [31:0] req_q[$];
    bit [31:0] tag_q[$];
    longint unsigned arena_base, arena_limit, run_off;
    res_t pending[$];
    int errors;
    // live allocations, for building sensible frees
    longint unsigned live[$];

    function void reset_state();
      base_q.delete(); size_q.delete(); free_q.delete();
      req_q.delete(); tag_q.delete(); pending.delete(); live.delete();
      arena_base = 0; arena_limit = 0; run_off = 0; errors = 0;
    endfunction

    function longint unsigned rnd(longint unsigned v, longint unsigned a);
      return (v + a - 1) & ~(a - 1);
    endfunction

    function void ins(int p, longint unsigned b, longint unsigned s);
      base_q.insert(p, b); size_q.insert(p, s); free_q.insert(p, 1'b1);
      req_q.insert(p, 0); tag_q.insert(p, 0);
    endfunction

    function void rem(int p);
      base_q.delete(p); size_q.delete(p); free_q.delete(p);
      req_q.delete(p); tag_q.delete(p);
    endfunction

    function res_t allocate(longint unsigned sz, bit [31:0] tg, bit zr);
      res_t r;
      longint unsigned al, need, addr, bb, bs, resv, lead, tail, a, want;
      int idx, extra;
      bit found;
      r = '0;
      if (sz == 0) begin
        r.status = ST_ZERO_SIZE;
        return r;
      end
      al = (sz >= PAGE) ? PAGE : SAL;
      need = rnd(sz, SAL);
      found = 0; idx = 0; addr = 0; bb = 0; bs = 0; resv = 0;
      for (int i = 0; i < base_q.size(); i++) begin
        if (!free_q[i]) continue;
        a = rnd(base_q[i], al);
        if (size_q[i] >= (a - base_q[i]) + need) begin
          idx = i; addr = a; bb = base_q[i]; bs = size_q[i]; found = 1;
          break;
        end
      end
      if (!found) begin
        want = need + al;
        if (want < RUNB) want = RUNB;
        resv = rnd(want, PAGE);
        bb = arena_base + run_off;
        if (run_off + resv > arena_limit || bb + resv > LIM48) begin
          r.status = ST_EXHAUSTED;
          return r;
        end
        bs = resv;
        addr = rnd(bb, al);
      end
      lead = addr - bb;
      tail = bs - lead - need;
      extra = (found ? 0 : 1) + (lead > 0) + (tail > 0);
      if (base_q.size() + extra > NBLK) begin
        r.status = ST_TABLE_FULL;
        return r;
      end
      if (!found) begin
        idx = 0;
        while (idx < base_q.size() && base_q[idx] <= bb) idx++;
        ins(idx, bb, bs);
        run_off += resv;
      end
      if (lead > 0) begin
        size_q[idx] = lead;
        ins(idx + 1, addr, bs - lead);
        idx++;
      end
      if (tail > 0) begin
        ins(idx + 1, addr + need, tail);
        size_q[idx] = need;
      end
      free_q[idx] = 0; req_q[idx] = sz[31:0]; tag_q[idx] = tg;
      live = {live, addr};
      r.status = ST_ALLOCATED;
      r.block_address = addr[47:0];
      r.zero_fill = zr;
      return r;
    endfunction

    function res_t release_block(longint unsigned addr);
      res_t r;
      int i;
      r = '0;
      i = 0;
      while (i < base_q.size() && base_q[i] != addr) i++;
      if (i >= base_q.size() || free_q[i]) begin
        r.status = ST_NOT_FOUND;
        return r;
      end
      r.status = ST_FREED; r.freed_size = req_q[i]; r.freed_tag = tag_q[i];
      free_q[i] = 1;
      if (i + 1 < base_q.size() && free_q[i+1] && addr + size_q[i] == base_q[i+1]
          && size_q[i] + size_q[i+1] <= MAX33) begin
        size_q[i] += size_q[i+1];
        rem(i + 1);
      end
      if (i > 0 && free_q[i-1] && base_q[i-1] + size_q[i-1] == addr
          && size_q[i-1] + size_q[i] <= MAX33) begin
        size_q[i-1] += size_q[i];
        rem(i);
      end
      return r;
    endfunction

    // note an accepted input word
    function void note_input(req_t w);
      if (w.command == CMD_ALLOC)
        pending = {pending, allocate(64'(w.request_size), w.owner_tag, w.zero_wanted)};
      else
        pending = {pending, release_block(64'(w.free_address))};
    endfunction

    // check a result word against the oldest expectation
    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0, start = 0, busy, out_valid, cfg_we = 0, cfg_index = 0;
  logic [47:0] cfg_wdata = '0;
  req_t in_data = '0;
  res_t out_data;
  pool_scoreboard sb;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  first_fit_pool_allocator_top DUT (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  // result monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    repeat (n) @(posedge clk);
  endtask

  // send one word; start is dropped afterwards only if no back-to-back word follows
  task automatic send(req_t w, bit idle_after);
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    sb.note_input(w);
    if (idle_after) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, longint unsigned v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v[47:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ARENA_BASE) sb.arena_base = v[47:0];
    else sb.arena_limit = v[47:0];
  endtask

  function automatic req_t mk_alloc(longint unsigned sz, bit [31:0] tg, bit zr);
    req_t w;
    w = '0;
    w.command = CMD_ALLOC; w.request_size = sz[31:0]; w.owner_tag = tg;
    w.zero_wanted = zr; w.free_address = 48'({$urandom, $urandom});
    return w;
  endfunction

  function automatic req_t mk_free(longint unsigned a);
    req_t w;
    w = '0;
    w.command = CMD_FREE; w.free_address = a[47:0];
    w.request_size = $urandom; w.owner_tag = $urandom; w.zero_wanted = 1'($urandom);
    return w;
  endfunction

  task automatic random_phase(int n);
    req_t w;
    longint unsigned sz, a;
    int k, pick;
    bit g;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        k = $urandom_range(0, 9);
        if (k < 6) sz = 64'($urandom_range(1, 600));
        else if (k < 8) sz = 64'($urandom_range(4096, 20000));
        else if (k == 8) sz = 64'($urandom_range(0, 3));
        else sz = 64'({$urandom} & 32'h003F_FFFF);
        w = mk_alloc(sz, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 90 && sb.live.size() != 0) begin
        k = $urandom_range(0, sb.live.size() - 1);
        a = sb.live[k];
        sb.live.delete(k);
        w = mk_free(a);
      end else begin
        a = {$urandom, $urandom};
        if ($urandom_range(0, 1)) a = sb.arena_base + 64'($urandom_range(0, 4096) << 4);
        w = mk_free(a);
      end
      // drop start only when an idle gap follows
      g = ($urandom_range(0, 3) == 0);
      send(w, g);
      if (g) gap();
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty arena: allocation exhausted, zero size and unknown free rejected
    send(mk_alloc(16, 32'h1, 1), 1);
    send(mk_alloc(0, 32'hFFFF_FFFF, 1), 1);
    send(mk_free(0), 1);
    drain();

    // small arena, directed corners
    set_reg(CFG_ARENA_BASE, 48'h0000_1000_0000);
    set_reg(CFG_ARENA_LIMIT, 48'h40_0000);
    send(mk_alloc(1, 32'hDEAD_BEEF, 1), 0);
    send(mk_alloc(17, 32'h0, 0), 0);
    send(mk_alloc(4096, 32'hFFFF_FFFF, 1), 0);
    send(mk_alloc(4095, 32'h5555_AAAA, 0), 0);
    send(mk_alloc(32'hFFFF_FFFF, 32'h1234_5678, 1), 0);
    send(mk_alloc(48'hF_FFF0, 32'h2, 0), 0);
    send(mk_free(48'h0000_1000_0000), 0);
    send(mk_free(48'h0000_1000_0000), 0);
    send(mk_free(48'hFFFF_FFFF_FFFF), 0);
    send(mk_free(48'h0000_1000_0010), 1);
    drain();

    // sender holds off until all results are back
    random_phase(120);
    drain();

    // arena at the top of the address space
    set_reg(CFG_ARENA_BASE, 48'hFFFF_FFE0_0000);
    set_reg(CFG_ARENA_LIMIT, 48'hFFFF_FFFF_FFFF);
    random_phase(140);
    drain();

    // base moved back over used space, large limit: table fills
    set_reg(CFG_ARENA_BASE, 48'h0000_1000_0000);
    set_reg(CFG_ARENA_LIMIT, 48'h0);
    set_reg(CFG_ARENA_LIMIT, 48'h0100_0000_0000);
    random_phase(140);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
